// ----- rtl/hafl_pkg.sv -----
// Shared types, constants and codes of the heap allocator.
package hafl_pkg;

   localparam int ADDR_BITS      = 16;
   localparam int MAX_BLOCKS     = 64;
   localparam int REGISTRY_DEPTH = 96;
   localparam int LEN_W          = ADDR_BITS + 1;
   localparam int CNT_W          = $clog2(MAX_BLOCKS + 1);
   localparam int FIDX_W         = $clog2(MAX_BLOCKS);
   localparam int SLOT_W         = $clog2(REGISTRY_DEPTH + 1);
   localparam int BIT_W          = $clog2(LEN_W);
   localparam logic [LEN_W-1:0] HEAP_MAX = LEN_W'(1) << ADDR_BITS;
   localparam logic [CNT_W-1:0] BLOCKS_MAX = CNT_W'(MAX_BLOCKS);

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_SIZE  = 3'd1,
      ST_LIVE_LIM  = 3'd2,
      ST_NO_MEM    = 3'd3,
      ST_OUT_RANGE = 3'd4,
      ST_NOT_FOUND = 3'd5,
      ST_FULL      = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      CSR_HEAP_BYTES = 2'd0,
      CSR_MAX_LIVE   = 2'd1
   } csr_index_type;

   typedef enum logic [0:0] {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef struct packed {
      logic              op;
      logic [LEN_W-1:0]  req_bytes;
      logic [LEN_W-1:0]  block_addr;
   } req_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0] granted_addr;
      status_type           status;
      logic [LEN_W-1:0]     allocated_total;
      logic [LEN_W-1:0]     available_total;
   } rsp_type;

   typedef enum logic [4:0] {
      C_NONE,
      C_LOAD,
      C_FAIL,
      C_BEGIN_BUMP,
      C_BEGIN_FREE,
      C_BEGIN_FIT,
      C_MOD_STEP,
      C_PROBE_NEXT,
      C_PM_RD,
      C_PM_HIT,
      C_RD_I,
      C_NEXT_I,
      C_INS_POS,
      C_SHUP_RD,
      C_SHUP_WR,
      C_INS_WR,
      C_FIT_HIT,
      C_CO_START,
      C_FIT_AGAIN,
      C_RD_ZERO,
      C_RD_J,
      C_SRT_LD,
      C_SRT_CK,
      C_SRT_LAST,
      C_MRG_LD,
      C_MRG_CK,
      C_MRG_LAST,
      C_ALLOC_UPD,
      C_SHDN_RD,
      C_SHDN_WR,
      C_SHDN_END,
      C_REC
   } dp_cmd_type;

   typedef struct packed {
      dp_cmd_type cmd;
      status_type code;
      logic       resp;
   } ctl_cmd_type;

   typedef struct packed {
      logic is_free;
      logic bad_size;
      logic live_full;
      logic from_bump;
      logic out_range;
      logic mod_last;
      logic probe_end;
      logic slot_empty;
      logic match;
      logic flist_full;
      logic scan_end;
      logic fit_ok;
      logic ins_here;
      logic shup_done;
      logic pass_end;
      logic few;
      logic count_zero;
      logic swapped;
      logic mode_len;
      logic coalesced;
      logic bump_sel;
      logic split;
      logic shdn_done;
      logic rsp_full;
   } dp_stat_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_CHECK,
      S_MOD,
      S_PE,
      S_PM_RD,
      S_PM_CK,
      S_INS_RD,
      S_INS_CK,
      S_SHUP,
      S_SHUP_WR,
      S_INS_WR,
      S_FIT_RD,
      S_FIT_CK,
      S_SRT_INIT,
      S_SRT_LD,
      S_SRT_RD,
      S_SRT_CK,
      S_SRT_END,
      S_MRG_LD,
      S_MRG_RD,
      S_MRG_CK,
      S_SHDN,
      S_SHDN_WR,
      S_REC,
      S_DONE
   } ctl_state_type;

endpackage

// ----- rtl/hafl_ctrl.sv -----
// Sequencer of the heap allocator: steps the datapath through each request.
module hafl_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  hafl_pkg::dp_stat_type stat,
   output hafl_pkg::ctl_cmd_type ctl
);

   hafl_pkg::ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hafl_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != hafl_pkg::S_IDLE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hafl_pkg::S_IDLE: begin
            if (req_valid) state_in = hafl_pkg::S_CHECK;
         end
         hafl_pkg::S_CHECK: begin
            if (stat.is_free) begin
               state_in = stat.out_range ? hafl_pkg::S_DONE : hafl_pkg::S_MOD;
            end else if (stat.bad_size || stat.live_full) begin
               state_in = hafl_pkg::S_DONE;
            end else if (stat.from_bump) begin
               state_in = hafl_pkg::S_MOD;
            end else begin
               state_in = hafl_pkg::S_FIT_RD;
            end
         end
         hafl_pkg::S_MOD: begin
            if (stat.mod_last) state_in = stat.is_free ? hafl_pkg::S_PM_RD : hafl_pkg::S_PE;
         end
         hafl_pkg::S_PE: begin
            priority if (stat.probe_end) state_in = hafl_pkg::S_DONE;
            else if (stat.slot_empty) begin
               state_in = (stat.bump_sel || stat.split) ? hafl_pkg::S_REC : hafl_pkg::S_SHDN;
            end else state_in = hafl_pkg::S_PE;
         end
         hafl_pkg::S_PM_RD: begin
            state_in = stat.probe_end ? hafl_pkg::S_DONE : hafl_pkg::S_PM_CK;
         end
         hafl_pkg::S_PM_CK: begin
            if (stat.match) begin
               state_in = stat.flist_full ? hafl_pkg::S_DONE : hafl_pkg::S_INS_RD;
            end else begin
               state_in = hafl_pkg::S_PM_RD;
            end
         end
         hafl_pkg::S_INS_RD: begin
            state_in = stat.scan_end ? hafl_pkg::S_SHUP : hafl_pkg::S_INS_CK;
         end
         hafl_pkg::S_INS_CK: begin
            state_in = stat.ins_here ? hafl_pkg::S_SHUP : hafl_pkg::S_INS_RD;
         end
         hafl_pkg::S_SHUP: begin
            state_in = stat.shup_done ? hafl_pkg::S_INS_WR : hafl_pkg::S_SHUP_WR;
         end
         hafl_pkg::S_SHUP_WR: state_in = hafl_pkg::S_SHUP;
         hafl_pkg::S_INS_WR:  state_in = hafl_pkg::S_DONE;
         hafl_pkg::S_FIT_RD: begin
            priority if (!stat.scan_end) state_in = hafl_pkg::S_FIT_CK;
            else if (stat.coalesced) state_in = hafl_pkg::S_DONE;
            else if (stat.count_zero) state_in = hafl_pkg::S_FIT_RD;
            else state_in = hafl_pkg::S_SRT_INIT;
         end
         hafl_pkg::S_FIT_CK: begin
            state_in = stat.fit_ok ? hafl_pkg::S_MOD : hafl_pkg::S_FIT_RD;
         end
         hafl_pkg::S_SRT_INIT: begin
            priority if (!stat.few) state_in = hafl_pkg::S_SRT_LD;
            else if (stat.mode_len) state_in = hafl_pkg::S_FIT_RD;
            else state_in = hafl_pkg::S_MRG_LD;
         end
         hafl_pkg::S_SRT_LD: state_in = hafl_pkg::S_SRT_RD;
         hafl_pkg::S_SRT_RD: begin
            state_in = stat.pass_end ? hafl_pkg::S_SRT_END : hafl_pkg::S_SRT_CK;
         end
         hafl_pkg::S_SRT_CK: state_in = hafl_pkg::S_SRT_RD;
         hafl_pkg::S_SRT_END: begin
            priority if (stat.swapped) state_in = hafl_pkg::S_SRT_INIT;
            else if (stat.mode_len) state_in = hafl_pkg::S_FIT_RD;
            else state_in = hafl_pkg::S_MRG_LD;
         end
         hafl_pkg::S_MRG_LD: state_in = hafl_pkg::S_MRG_RD;
         hafl_pkg::S_MRG_RD: begin
            state_in = stat.pass_end ? hafl_pkg::S_SRT_INIT : hafl_pkg::S_MRG_CK;
         end
         hafl_pkg::S_MRG_CK: state_in = hafl_pkg::S_MRG_RD;
         hafl_pkg::S_SHDN: begin
            state_in = stat.shdn_done ? hafl_pkg::S_REC : hafl_pkg::S_SHDN_WR;
         end
         hafl_pkg::S_SHDN_WR: state_in = hafl_pkg::S_SHDN;
         hafl_pkg::S_REC:     state_in = hafl_pkg::S_DONE;
         hafl_pkg::S_DONE: begin
            if (!stat.rsp_full) state_in = hafl_pkg::S_IDLE;
         end
         default: state_in = hafl_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      ctl.cmd  = hafl_pkg::C_NONE;
      ctl.code = hafl_pkg::ST_OK;
      ctl.resp = 1'b0;
      unique case (state_ff)
         hafl_pkg::S_IDLE: begin
            if (req_valid) ctl.cmd = hafl_pkg::C_LOAD;
         end
         hafl_pkg::S_CHECK: begin
            if (stat.is_free) begin
               if (stat.out_range) begin
                  ctl.cmd  = hafl_pkg::C_FAIL;
                  ctl.code = hafl_pkg::ST_OUT_RANGE;
               end else begin
                  ctl.cmd = hafl_pkg::C_BEGIN_FREE;
               end
            end else if (stat.bad_size) begin
               ctl.cmd  = hafl_pkg::C_FAIL;
               ctl.code = hafl_pkg::ST_BAD_SIZE;
            end else if (stat.live_full) begin
               ctl.cmd  = hafl_pkg::C_FAIL;
               ctl.code = hafl_pkg::ST_LIVE_LIM;
            end else if (stat.from_bump) begin
               ctl.cmd = hafl_pkg::C_BEGIN_BUMP;
            end else begin
               ctl.cmd = hafl_pkg::C_BEGIN_FIT;
            end
         end
         hafl_pkg::S_MOD: ctl.cmd = hafl_pkg::C_MOD_STEP;
         hafl_pkg::S_PE: begin
            priority if (stat.probe_end) begin
               ctl.cmd  = hafl_pkg::C_FAIL;
               ctl.code = hafl_pkg::ST_FULL;
            end else if (stat.slot_empty) ctl.cmd = hafl_pkg::C_ALLOC_UPD;
            else ctl.cmd = hafl_pkg::C_PROBE_NEXT;
         end
         hafl_pkg::S_PM_RD: begin
            if (stat.probe_end) begin
               ctl.cmd  = hafl_pkg::C_FAIL;
               ctl.code = hafl_pkg::ST_NOT_FOUND;
            end else begin
               ctl.cmd = hafl_pkg::C_PM_RD;
            end
         end
         hafl_pkg::S_PM_CK: begin
            if (stat.match) begin
               if (stat.flist_full) begin
                  ctl.cmd  = hafl_pkg::C_FAIL;
                  ctl.code = hafl_pkg::ST_FULL;
               end else begin
                  ctl.cmd = hafl_pkg::C_PM_HIT;
               end
            end else begin
               ctl.cmd = hafl_pkg::C_PROBE_NEXT;
            end
         end
         hafl_pkg::S_INS_RD: begin
            ctl.cmd = stat.scan_end ? hafl_pkg::C_INS_POS : hafl_pkg::C_RD_I;
         end
         hafl_pkg::S_INS_CK: begin
            ctl.cmd = stat.ins_here ? hafl_pkg::C_INS_POS : hafl_pkg::C_NEXT_I;
         end
         hafl_pkg::S_SHUP: begin
            if (!stat.shup_done) ctl.cmd = hafl_pkg::C_SHUP_RD;
         end
         hafl_pkg::S_SHUP_WR: ctl.cmd = hafl_pkg::C_SHUP_WR;
         hafl_pkg::S_INS_WR:  ctl.cmd = hafl_pkg::C_INS_WR;
         hafl_pkg::S_FIT_RD: begin
            priority if (!stat.scan_end) ctl.cmd = hafl_pkg::C_RD_I;
            else if (stat.coalesced) begin
               ctl.cmd  = hafl_pkg::C_FAIL;
               ctl.code = hafl_pkg::ST_NO_MEM;
            end else if (stat.count_zero) ctl.cmd = hafl_pkg::C_FIT_AGAIN;
            else ctl.cmd = hafl_pkg::C_CO_START;
         end
         hafl_pkg::S_FIT_CK: begin
            ctl.cmd = stat.fit_ok ? hafl_pkg::C_FIT_HIT : hafl_pkg::C_NEXT_I;
         end
         hafl_pkg::S_SRT_INIT: begin
            priority if (!stat.few) ctl.cmd = hafl_pkg::C_RD_ZERO;
            else if (stat.mode_len) ctl.cmd = hafl_pkg::C_FIT_AGAIN;
            else ctl.cmd = hafl_pkg::C_RD_ZERO;
         end
         hafl_pkg::S_SRT_LD: ctl.cmd = hafl_pkg::C_SRT_LD;
         hafl_pkg::S_SRT_RD: begin
            ctl.cmd = stat.pass_end ? hafl_pkg::C_SRT_LAST : hafl_pkg::C_RD_J;
         end
         hafl_pkg::S_SRT_CK: ctl.cmd = hafl_pkg::C_SRT_CK;
         hafl_pkg::S_SRT_END: begin
            priority if (stat.swapped) ctl.cmd = hafl_pkg::C_NONE;
            else if (stat.mode_len) ctl.cmd = hafl_pkg::C_FIT_AGAIN;
            else ctl.cmd = hafl_pkg::C_RD_ZERO;
         end
         hafl_pkg::S_MRG_LD: ctl.cmd = hafl_pkg::C_MRG_LD;
         hafl_pkg::S_MRG_RD: begin
            ctl.cmd = stat.pass_end ? hafl_pkg::C_MRG_LAST : hafl_pkg::C_RD_J;
         end
         hafl_pkg::S_MRG_CK: ctl.cmd = hafl_pkg::C_MRG_CK;
         hafl_pkg::S_SHDN: begin
            ctl.cmd = stat.shdn_done ? hafl_pkg::C_SHDN_END : hafl_pkg::C_SHDN_RD;
         end
         hafl_pkg::S_SHDN_WR: ctl.cmd = hafl_pkg::C_SHDN_WR;
         hafl_pkg::S_REC:     ctl.cmd = hafl_pkg::C_REC;
         hafl_pkg::S_DONE: begin
            ctl.resp = !stat.rsp_full;
         end
         default: ctl.cmd = hafl_pkg::C_NONE;
      endcase
   end

endmodule

// ----- rtl/hafl_dp.sv -----
// Datapath of the heap allocator: counters, free list, block registry and result register.
module hafl_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  hafl_pkg::ctl_cmd_type                  ctl,
   output hafl_pkg::dp_stat_type                  stat,
   input  hafl_pkg::req_type                      req_data,
   input  logic                                   csr_we,
   input  logic [1:0]                             csr_index,
   input  logic [hafl_pkg::LEN_W-1:0]             csr_wdata,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output hafl_pkg::rsp_type                      rsp_data
);

   localparam int LW = hafl_pkg::LEN_W;
   localparam int AW = hafl_pkg::ADDR_BITS;
   localparam int CW = hafl_pkg::CNT_W;
   localparam int FW = hafl_pkg::FIDX_W;
   localparam int SW = hafl_pkg::SLOT_W;
   localparam int BW = hafl_pkg::BIT_W;
   localparam int RD = hafl_pkg::REGISTRY_DEPTH;

   logic [LW-1:0] heap_ff, heap_in;
   logic [CW-1:0] maxb_ff, maxb_in;
   logic [SW-1:0] nslot_ff, nslot_in;
   logic [LW-1:0] bump_ff, bump_in;
   logic [CW-1:0] fcnt_ff, fcnt_in;
   logic [CW-1:0] lcnt_ff, lcnt_in;
   logic [LW-1:0] lbytes_ff, lbytes_in;
   logic [RD-1:0] valid_ff, valid_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic                 op_ff, op_in;
   logic [LW-1:0]        req_ff, req_in;
   logic [LW-1:0]        tgt_ff, tgt_in;
   logic [LW-1:0]        key_ff, key_in;
   logic [SW-1:0]        rem_ff, rem_in;
   logic [BW-1:0]        bit_ff, bit_in;
   logic [SW-1:0]        idx_ff, idx_in;
   logic [SW-1:0]        k_ff, k_in;
   logic [CW-1:0]        i_ff, i_in;
   logic [CW-1:0]        j_ff, j_in;
   logic [FW-1:0]        w_ff, w_in;
   logic [AW-1:0]        cur_s_ff, cur_s_in;
   logic [LW-1:0]        cur_l_ff, cur_l_in;
   logic [LW-1:0]        len_ff, len_in;
   logic                 swap_ff, swap_in;
   logic                 mode_ff, mode_in;
   logic                 coal_ff, coal_in;
   logic                 bsel_ff, bsel_in;
   hafl_pkg::status_type status_ff, status_in;
   logic [AW-1:0]        addr_ff, addr_in;
   hafl_pkg::rsp_type    rsp_ff, rsp_in;

   logic [AW-1:0] fs_mem [hafl_pkg::MAX_BLOCKS];
   logic [LW-1:0] fl_mem [hafl_pkg::MAX_BLOCKS];
   logic [AW-1:0] rs_mem [RD];
   logic [LW-1:0] rl_mem [RD];
   logic [AW-1:0] fq_s_ff;
   logic [LW-1:0] fq_l_ff;
   logic [AW-1:0] rq_s_ff;
   logic [LW-1:0] rq_l_ff;

   logic          f_re, f_we, r_re, r_we;
   logic [FW-1:0] f_ra, f_wa;
   logic [AW-1:0] f_wd_s;
   logic [LW-1:0] f_wd_l;

   logic [SW:0]   mod_t, mod_r;
   logic [SW-1:0] idx_inc, idx_nx;
   logic [CW-1:0] j_m1, j_p1, fcnt_m1;
   logic          ooo, touch;
   logic [LW:0]   cur_end;
   logic [LW-1:0] cfg_heap;
   logic [CW-1:0] cfg_maxb;
   logic [LW-1:0] avail;
   logic          cfg_hit;

   assign mod_t   = {rem_ff, key_ff[bit_ff]};
   assign mod_r   = (mod_t >= {1'b0, nslot_ff}) ? mod_t - {1'b0, nslot_ff} : mod_t;
   assign idx_inc = idx_ff + SW'(1);
   assign idx_nx  = (idx_inc == nslot_ff) ? '0 : idx_inc;
   assign j_m1    = j_ff - CW'(1);
   assign j_p1    = j_ff + CW'(1);
   assign fcnt_m1 = fcnt_ff - CW'(1);
   assign cur_end = {1'b0, LW'(cur_s_ff)} + {1'b0, cur_l_ff};
   assign touch   = (cur_end == {1'b0, LW'(fq_s_ff)});
   assign ooo     = mode_ff ? ((cur_l_ff < fq_l_ff) ||
                               ((cur_l_ff == fq_l_ff) && (cur_s_ff > fq_s_ff)))
                            : (cur_s_ff > fq_s_ff);
   assign avail   = (heap_ff >= lbytes_ff) ? heap_ff - lbytes_ff : '0;

   assign cfg_heap = (csr_wdata == '0) ? LW'(1) :
                     (csr_wdata > hafl_pkg::HEAP_MAX) ? hafl_pkg::HEAP_MAX : csr_wdata;
   assign cfg_maxb = (csr_wdata[CW-1:0] == '0) ? CW'(1) :
                     (csr_wdata[CW-1:0] > hafl_pkg::BLOCKS_MAX) ? hafl_pkg::BLOCKS_MAX
                                                                : csr_wdata[CW-1:0];
   assign cfg_hit  = csr_we && ((csr_index == hafl_pkg::CSR_HEAP_BYTES) ||
                                (csr_index == hafl_pkg::CSR_MAX_LIVE));

   always_comb begin
      heap_in      = heap_ff;
      maxb_in      = maxb_ff;
      nslot_in     = nslot_ff;
      if (csr_we && (csr_index == hafl_pkg::CSR_HEAP_BYTES)) heap_in = cfg_heap;
      if (csr_we && (csr_index == hafl_pkg::CSR_MAX_LIVE)) begin
         maxb_in  = cfg_maxb;
         nslot_in = SW'(cfg_maxb) + SW'(cfg_maxb >> 1);
      end
   end

   always_comb begin
      bump_in      = bump_ff;
      fcnt_in      = fcnt_ff;
      lcnt_in      = lcnt_ff;
      lbytes_in    = lbytes_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      op_in        = op_ff;
      req_in       = req_ff;
      tgt_in       = tgt_ff;
      key_in       = key_ff;
      rem_in       = rem_ff;
      bit_in       = bit_ff;
      idx_in       = idx_ff;
      k_in         = k_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      w_in         = w_ff;
      cur_s_in     = cur_s_ff;
      cur_l_in     = cur_l_ff;
      len_in       = len_ff;
      swap_in      = swap_ff;
      mode_in      = mode_ff;
      coal_in      = coal_ff;
      bsel_in      = bsel_ff;
      status_in    = status_ff;
      addr_in      = addr_ff;
      rsp_in       = rsp_ff;
      f_re         = 1'b0;
      f_ra         = '0;
      f_we         = 1'b0;
      f_wa         = '0;
      f_wd_s       = '0;
      f_wd_l       = '0;
      r_re         = 1'b0;
      r_we         = 1'b0;

      unique case (ctl.cmd)
         hafl_pkg::C_NONE: begin
         end
         hafl_pkg::C_LOAD: begin
            op_in  = req_data.op;
            req_in = req_data.req_bytes;
            tgt_in = req_data.block_addr;
         end
         hafl_pkg::C_FAIL: begin
            status_in = ctl.code;
            addr_in   = '0;
         end
         hafl_pkg::C_BEGIN_BUMP: begin
            key_in  = bump_ff;
            bsel_in = 1'b1;
            rem_in  = '0;
            bit_in  = BW'(LW - 1);
         end
         hafl_pkg::C_BEGIN_FREE: begin
            key_in = tgt_ff;
            rem_in = '0;
            bit_in = BW'(LW - 1);
         end
         hafl_pkg::C_BEGIN_FIT: begin
            i_in    = '0;
            coal_in = 1'b0;
         end
         hafl_pkg::C_MOD_STEP: begin
            rem_in = mod_r[SW-1:0];
            idx_in = mod_r[SW-1:0];
            bit_in = bit_ff - BW'(1);
            k_in   = '0;
         end
         hafl_pkg::C_PROBE_NEXT: begin
            idx_in = idx_nx;
            k_in   = k_ff + SW'(1);
         end
         hafl_pkg::C_PM_RD: r_re = 1'b1;
         hafl_pkg::C_PM_HIT: begin
            len_in = rq_l_ff;
            i_in   = '0;
         end
         hafl_pkg::C_RD_I: begin
            f_re = 1'b1;
            f_ra = i_ff[FW-1:0];
         end
         hafl_pkg::C_NEXT_I: i_in = i_ff + CW'(1);
         hafl_pkg::C_INS_POS: j_in = fcnt_ff;
         hafl_pkg::C_SHUP_RD: begin
            f_re = 1'b1;
            f_ra = j_m1[FW-1:0];
         end
         hafl_pkg::C_SHUP_WR: begin
            f_we   = 1'b1;
            f_wa   = j_ff[FW-1:0];
            f_wd_s = fq_s_ff;
            f_wd_l = fq_l_ff;
            j_in   = j_m1;
         end
         hafl_pkg::C_INS_WR: begin
            f_we            = 1'b1;
            f_wa            = i_ff[FW-1:0];
            f_wd_s          = key_ff[AW-1:0];
            f_wd_l          = len_ff;
            fcnt_in         = fcnt_ff + CW'(1);
            valid_in[idx_ff] = 1'b0;
            lbytes_in       = (lbytes_ff >= len_ff) ? lbytes_ff - len_ff : '0;
            lcnt_in         = (lcnt_ff != '0) ? lcnt_ff - CW'(1) : '0;
            status_in       = hafl_pkg::ST_OK;
            addr_in         = '0;
         end
         hafl_pkg::C_FIT_HIT: begin
            key_in  = LW'(fq_s_ff);
            len_in  = fq_l_ff;
            bsel_in = 1'b0;
            rem_in  = '0;
            bit_in  = BW'(LW - 1);
         end
         hafl_pkg::C_CO_START: mode_in = 1'b0;
         hafl_pkg::C_FIT_AGAIN: begin
            coal_in = 1'b1;
            i_in    = '0;
         end
         hafl_pkg::C_RD_ZERO: begin
            f_re = 1'b1;
            f_ra = '0;
         end
         hafl_pkg::C_RD_J: begin
            f_re = 1'b1;
            f_ra = j_ff[FW-1:0];
         end
         hafl_pkg::C_SRT_LD: begin
            cur_s_in = fq_s_ff;
            cur_l_in = fq_l_ff;
            j_in     = CW'(1);
            swap_in  = 1'b0;
         end
         hafl_pkg::C_SRT_CK: begin
            f_we = 1'b1;
            f_wa = j_m1[FW-1:0];
            if (ooo) begin
               f_wd_s  = fq_s_ff;
               f_wd_l  = fq_l_ff;
               swap_in = 1'b1;
            end else begin
               f_wd_s   = cur_s_ff;
               f_wd_l   = cur_l_ff;
               cur_s_in = fq_s_ff;
               cur_l_in = fq_l_ff;
            end
            j_in = j_p1;
         end
         hafl_pkg::C_SRT_LAST: begin
            f_we   = 1'b1;
            f_wa   = fcnt_m1[FW-1:0];
            f_wd_s = cur_s_ff;
            f_wd_l = cur_l_ff;
         end
         hafl_pkg::C_MRG_LD: begin
            cur_s_in = fq_s_ff;
            cur_l_in = fq_l_ff;
            w_in     = '0;
            j_in     = CW'(1);
         end
         hafl_pkg::C_MRG_CK: begin
            if (touch) begin
               cur_l_in = cur_l_ff + fq_l_ff;
            end else begin
               f_we     = 1'b1;
               f_wa     = w_ff;
               f_wd_s   = cur_s_ff;
               f_wd_l   = cur_l_ff;
               w_in     = w_ff + FW'(1);
               cur_s_in = fq_s_ff;
               cur_l_in = fq_l_ff;
            end
            j_in = j_p1;
         end
         hafl_pkg::C_MRG_LAST: begin
            f_we    = 1'b1;
            f_wa    = w_ff;
            f_wd_s  = cur_s_ff;
            f_wd_l  = cur_l_ff;
            fcnt_in = CW'(w_ff) + CW'(1);
            mode_in = 1'b1;
         end
         hafl_pkg::C_ALLOC_UPD: begin
            if (bsel_ff) begin
               bump_in = bump_ff + req_ff;
            end else if (len_ff > req_ff) begin
               f_we   = 1'b1;
               f_wa   = i_ff[FW-1:0];
               f_wd_s = key_ff[AW-1:0] + req_ff[AW-1:0];
               f_wd_l = len_ff - req_ff;
            end else begin
               j_in = i_ff;
            end
         end
         hafl_pkg::C_SHDN_RD: begin
            f_re = 1'b1;
            f_ra = j_p1[FW-1:0];
         end
         hafl_pkg::C_SHDN_WR: begin
            f_we   = 1'b1;
            f_wa   = j_ff[FW-1:0];
            f_wd_s = fq_s_ff;
            f_wd_l = fq_l_ff;
            j_in   = j_p1;
         end
         hafl_pkg::C_SHDN_END: fcnt_in = fcnt_m1;
         hafl_pkg::C_REC: begin
            r_we             = 1'b1;
            valid_in[idx_ff] = 1'b1;
            lbytes_in        = lbytes_ff + req_ff;
            lcnt_in          = lcnt_ff + CW'(1);
            status_in        = hafl_pkg::ST_OK;
            addr_in          = key_ff[AW-1:0];
         end
         default: begin
         end
      endcase

      if (ctl.resp) begin
         rsp_valid_in           = 1'b1;
         rsp_in.granted_addr    = addr_ff;
         rsp_in.status          = status_ff;
         rsp_in.allocated_total = lbytes_ff;
         rsp_in.available_total = avail;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_ff      <= hafl_pkg::HEAP_MAX;
         maxb_ff      <= hafl_pkg::BLOCKS_MAX;
         nslot_ff     <= SW'(hafl_pkg::MAX_BLOCKS + hafl_pkg::MAX_BLOCKS / 2);
         bump_ff      <= '0;
         fcnt_ff      <= '0;
         lcnt_ff      <= '0;
         lbytes_ff    <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (cfg_hit) begin
         heap_ff      <= heap_in;
         maxb_ff      <= maxb_in;
         nslot_ff     <= nslot_in;
         bump_ff      <= '0;
         fcnt_ff      <= '0;
         lcnt_ff      <= '0;
         lbytes_ff    <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= rsp_valid_in;
      end else begin
         bump_ff      <= bump_in;
         fcnt_ff      <= fcnt_in;
         lcnt_ff      <= lcnt_in;
         lbytes_ff    <= lbytes_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      req_ff    <= req_in;
      tgt_ff    <= tgt_in;
      key_ff    <= key_in;
      rem_ff    <= rem_in;
      bit_ff    <= bit_in;
      idx_ff    <= idx_in;
      k_ff      <= k_in;
      i_ff      <= i_in;
      j_ff      <= j_in;
      w_ff      <= w_in;
      cur_s_ff  <= cur_s_in;
      cur_l_ff  <= cur_l_in;
      len_ff    <= len_in;
      swap_ff   <= swap_in;
      mode_ff   <= mode_in;
      coal_ff   <= coal_in;
      bsel_ff   <= bsel_in;
      status_ff <= status_in;
      addr_ff   <= addr_in;
      rsp_ff    <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (f_we) begin
         fs_mem[f_wa] <= f_wd_s;
         fl_mem[f_wa] <= f_wd_l;
      end
      if (f_re) begin
         fq_s_ff <= fs_mem[f_ra];
         fq_l_ff <= fl_mem[f_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (r_we) begin
         rs_mem[idx_ff] <= key_ff[AW-1:0];
         rl_mem[idx_ff] <= req_ff;
      end
      if (r_re) begin
         rq_s_ff <= rs_mem[idx_ff];
         rq_l_ff <= rl_mem[idx_ff];
      end
   end

   assign stat.is_free    = (op_ff == hafl_pkg::OP_FREE);
   assign stat.bad_size   = (req_ff == '0) || (req_ff > heap_ff);
   assign stat.live_full  = (lcnt_ff >= maxb_ff);
   assign stat.from_bump  = (bump_ff < heap_ff) && (req_ff <= heap_ff - bump_ff);
   assign stat.out_range  = (tgt_ff > heap_ff);
   assign stat.mod_last   = (bit_ff == '0);
   assign stat.probe_end  = (k_ff == nslot_ff);
   assign stat.slot_empty = !valid_ff[idx_ff];
   assign stat.match      = valid_ff[idx_ff] && (LW'(rq_s_ff) == key_ff);
   assign stat.flist_full = (fcnt_ff >= maxb_ff);
   assign stat.scan_end   = (i_ff == fcnt_ff);
   assign stat.fit_ok     = (fq_l_ff >= req_ff);
   assign stat.ins_here   = (fq_l_ff < len_ff);
   assign stat.shup_done  = (j_ff == i_ff);
   assign stat.pass_end   = (j_ff == fcnt_ff);
   assign stat.few        = (fcnt_ff < CW'(2));
   assign stat.count_zero = (fcnt_ff == '0);
   assign stat.swapped    = swap_ff;
   assign stat.mode_len   = mode_ff;
   assign stat.coalesced  = coal_ff;
   assign stat.bump_sel   = bsel_ff;
   assign stat.split      = (len_ff > req_ff);
   assign stat.shdn_done  = (j_p1 >= fcnt_ff);
   assign stat.rsp_full   = rsp_valid_ff && rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_live_matches_registry: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(lcnt_ff))
      else $error("live count differs from registry occupancy");

   a_free_list_bound: assert property (@(posedge clock) disable iff (reset)
      fcnt_ff <= maxb_ff)
      else $error("free list holds more entries than allowed");

   a_live_bytes_bound: assert property (@(posedge clock) disable iff (reset)
      lbytes_ff <= heap_ff)
      else $error("live bytes exceed heap size");

   a_record_ok: assert property (@(posedge clock) disable iff (reset)
      (ctl.cmd == hafl_pkg::C_REC) |=> (status_ff == hafl_pkg::ST_OK) && valid_ff[$past(idx_ff)])
      else $error("recorded block did not mark its slot");

endmodule

// ----- rtl/heap_allocator_free_list.sv -----
// Top level of the heap allocator: sequencer plus datapath.
// Requests arrive on req_valid / req_stall with req_data (op, req_bytes, block_addr).
// A request is taken when req_valid is high and req_stall is low; one result per
// request leaves on rsp_valid / rsp_stall with rsp_data, in request order.
// One request is worked on at a time; req_stall stays high until its result
// has been written to the output register, which can still be waiting.
// An allocation from the bump pointer probes occupied registry slots until it finds a
// free one; the remainder for the home slot comes from a 17-step shift-subtract
// unit. A free probes registry slots for the block, scans free-list entries for its
// place and moves entries to open a gap.
// When no free entry fits, the free list is sorted with bubble passes, merged and
// sorted again through its memory, one entry read or written at a time.
// Reset or a write to either register empties the allocator at once; no clearing
// pass is needed. Register writes belong to idle periods only.
// While rsp_stall is high the result holds, and the next request waits in the
// final state until the output register is free.
module heap_allocator_free_list (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  hafl_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output hafl_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [1:0]                          csr_index,
   input  logic [hafl_pkg::LEN_W-1:0]          csr_wdata
);

   hafl_pkg::ctl_cmd_type ctl;
   hafl_pkg::dp_stat_type stat;

   hafl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .ctl       (ctl)
   );

   hafl_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .stat      (stat),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
